FILE: rtl/rtp_g711_payload_decoder_macros.svh
// Assertion macros used by the checker of the RTP G.711 decoder.
// Each macro samples on clk and is disabled while rst is high.
`ifndef RTP_G711_PAYLOAD_DECODER_MACROS_SVH
`define RTP_G711_PAYLOAD_DECODER_MACROS_SVH

// Same-cycle implication
`define RTPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RTPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rtpg_pkg.sv
`timescale 1ns / 1ps

package rtpg_pkg;

  // Fixed RTP header
  localparam logic [3:0] HDR_LEN     = 4'd12;
  localparam logic [1:0] RTP_V2      = 2'd2;
  localparam logic [6:0] PT_PCMU     = 7'd0;
  localparam logic [6:0] PT_PCMA     = 7'd8;

  // G.711 expansion constants
  localparam logic [7:0]  ALAW_XOR  = 8'h55;
  localparam logic [15:0] ALAW_BIAS = 16'h0108;
  localparam logic [15:0] ALAW_SEG0 = 16'h0008;
  localparam logic [15:0] ULAW_BIAS = 16'h0084;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SAMPLE      = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  // One classified byte waiting for expansion
  typedef struct packed {
    logic [7:0] code;
    logic       alaw;
    status_t    status;
    logic       eop;
  } item_t;

  // A-law code to linear PCM
  function automatic logic signed [15:0] alaw_expand(input logic [7:0] code);
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [15:0] mag;
    a   = code ^ ALAW_XOR;
    seg = a[6:4];
    mag = {8'd0, a[3:0], 4'd0};
    if (seg == 3'd0) begin
      mag = mag + ALAW_SEG0;
    end else begin
      mag = (mag + ALAW_BIAS) << (seg - 3'd1);
    end
    return a[7] ? signed'(mag) : signed'(16'd0 - mag);
  endfunction

  // u-law code to linear PCM
  function automatic logic signed [15:0] ulaw_expand(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] mag;
    u   = ~code;
    mag = {9'd0, u[3:0], 3'd0} + ULAW_BIAS;
    mag = mag << u[6:4];
    return u[7] ? signed'(ULAW_BIAS - mag) : signed'(mag - ULAW_BIAS);
  endfunction

endpackage

FILE: rtl/rtpg_hdr_track.sv
`timescale 1ns / 1ps

module rtpg_hdr_track (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // [7:0] data_byte
  input  logic           s_tlast,   // last_byte
  output logic           item_valid,
  output rtpg_pkg::item_t item,
  input  logic           item_ready
);
  import rtpg_pkg::*;

  logic [3:0] header_position;
  logic [3:0] header_position_next;
  logic [1:0] version_field;
  logic [6:0] payload_kind;
  logic       accept;
  logic       in_header;
  logic [3:0] pos_inc;
  status_t    hdr_status;
  logic       emit;
  item_t      item_next;

  assign s_tready = !item_valid || item_ready;
  assign accept   = s_tvalid && s_tready;

  // Header check on latched fields
  always_comb begin
    if (version_field != RTP_V2) begin
      hdr_status = ST_BAD_VERSION;
    end else if (payload_kind != PT_PCMU && payload_kind != PT_PCMA) begin
      hdr_status = ST_UNSUPPORTED;
    end else begin
      hdr_status = ST_SAMPLE;
    end
  end

  // Classify the incoming byte
  always_comb begin
    in_header      = header_position < HDR_LEN;
    pos_inc        = header_position + 4'd1;
    emit           = 1'b0;
    item_next.code = s_tdata;
    item_next.alaw = payload_kind == PT_PCMA;
    item_next.eop  = s_tlast;
    item_next.status = ST_SAMPLE;
    if (in_header) begin
      emit = s_tlast;
      if (pos_inc < HDR_LEN) begin
        item_next.status = ST_SHORT;
      end else if (hdr_status == ST_SAMPLE) begin
        item_next.status = ST_EMPTY;
      end else begin
        item_next.status = hdr_status;
      end
    end else begin
      item_next.status = hdr_status;
      emit = (hdr_status == ST_SAMPLE) || s_tlast;
    end
    if (s_tlast) begin
      header_position_next = 4'd0;
    end else if (in_header) begin
      header_position_next = pos_inc;
    end else begin
      header_position_next = header_position;
    end
  end

  // Header state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= 4'd0;
      version_field   <= 2'd0;
      payload_kind    <= 7'd0;
    end else if (accept) begin
      header_position <= header_position_next;
      if (header_position == 4'd0) begin
        version_field <= s_tdata[7:6];
      end
      if (header_position == 4'd1) begin
        payload_kind <= s_tdata[6:0];
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/rtpg_expand.sv
`timescale 1ns / 1ps

module rtpg_expand (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  rtpg_pkg::item_t item,
  output logic            item_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata,   // [15:0] sample, [18:16] status, [23:19] zero
  output logic            m_tlast    // end_of_packet
);
  import rtpg_pkg::*;

  logic signed [15:0] sample;
  logic signed [15:0] sample_next;
  status_t            status;
  logic               eop;

  assign item_ready = !m_tvalid || m_tready;

  // G.711 expansion; status results carry a zero sample
  always_comb begin
    if (item.status != ST_SAMPLE) begin
      sample_next = 16'sd0;
    end else if (item.alaw) begin
      sample_next = alaw_expand(item.code);
    end else begin
      sample_next = ulaw_expand(item.code);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_ready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      sample <= sample_next;
      status <= item.status;
      eop    <= item.eop;
    end
  end

  assign m_tdata = {5'd0, status, sample};
  assign m_tlast = eop;

endmodule

FILE: rtl/rtp_g711_payload_decoder.sv
`timescale 1ns / 1ps

// RTP G.711 payload decoder. Takes one RTP packet byte per transaction on the
// slave side (tlast on the packet's final byte) and sustains one byte per
// cycle while m_tready is high. The 12-byte header is counted and the version
// and payload type are latched; each payload byte of a version-2 PCMU (type 0)
// or PCMA (type 8) packet yields one signed 16-bit sample, tlast marking the
// packet's last. Short, bad-version, unsupported-type and empty packets give a
// single status result on their last byte; other header and rejected payload
// bytes give none. A result passes through the header-tracking stage register
// and then the output register; the G.711 expansion is done on the way into
// the output register. s_tready follows m_tready combinationally whenever both
// registers are occupied.
module rtp_g711_payload_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] sample, [18:16] status, [23:19] zero
  output logic        m_tlast    // end_of_packet
);
  import rtpg_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Header tracking and byte classification
  rtpg_hdr_track u_hdr_track (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  // Sample expansion and output register
  rtpg_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: rtl/rtpg_checker.sv
`timescale 1ns / 1ps
`include "rtp_g711_payload_decoder_macros.svh"

module rtpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,   // [15:0] sample, [18:16] status, [23:19] zero
  input logic        m_tlast    // end_of_packet
);
  import rtpg_pkg::*;

  logic status_err;

  assign status_err = m_tdata[18:16] != ST_SAMPLE;

  // Status results carry a zero sample
  `RTPG_ASSERT_IMP(a_status_zero_sample, m_tvalid && status_err, m_tdata[15:0] == 16'd0, "status result with nonzero sample")

  // Status results always close a packet
  `RTPG_ASSERT_IMP(a_status_is_last, m_tvalid && status_err, m_tlast, "status result without tlast")

  // With the output register empty the input side is never stalled
  `RTPG_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

  // Pad bits of tdata stay zero
  `RTPG_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[23:19] == 5'd0, "nonzero tdata padding")

  // A stalled result holds
  `RTPG_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind rtp_g711_payload_decoder rtpg_checker u_checker (.*);
